### hdl/gsp_pkg.sv
// ----------------------------------------------------------------------------
// gsp_pkg
// Shared codes, field widths and control groups of the square partitioner.
// ----------------------------------------------------------------------------
package gsp_pkg;

  localparam int CFG_REG_W = 7;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

  localparam int ACT_W = 2;
  localparam logic [ACT_W-1:0] ACT_LOAD = 2'd0;
  localparam logic [ACT_W-1:0] ACT_RUN  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ = 2'd2;

  localparam int POS_W = 6;
  localparam int IDX_W = 12;
  localparam int CNT_W = 13;
  localparam int LEN_W = 7;

  typedef struct packed {
    logic start;
    logic load;
    logic load_bit;
  } run_cmd_t;

  typedef struct packed {
    logic clear;
    logic push;
  } list_ctl_t;

endpackage

### hdl/gsp_run.sv
// ----------------------------------------------------------------------------
// gsp_run
// Pixel store, node store and walk queue with the sequencer that builds the
// partition and streams the surviving squares out in raster order.
// ----------------------------------------------------------------------------
module gsp_run #(
  parameter int MAX_DIM = 64
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  gsp_pkg::run_cmd_t                      cmd,
  input  logic [2*$clog2(MAX_DIM)-1:0]           load_addr,
  input  logic [gsp_pkg::CFG_REG_W-1:0]          cfg_w,
  input  logic [gsp_pkg::CFG_REG_W-1:0]          cfg_h,
  output logic                                   done,
  output gsp_pkg::list_ctl_t                     list_ctl,
  output logic [$clog2(MAX_DIM)-1:0]             list_x,
  output logic [$clog2(MAX_DIM)-1:0]             list_y,
  output logic [$clog2(MAX_DIM):0]               list_len
);

  localparam int CW     = $clog2(MAX_DIM);
  localparam int LW     = CW + 1;
  localparam int NW     = LW + 1;
  localparam int AW     = 2 * CW;
  localparam int DEPTH  = 1 << AW;
  localparam int QW     = AW + 1;
  localparam int QDEPTH = 1 << QW;
  localparam int AAW    = 2 * LW;

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_INIT     = 5'd1;
  localparam logic [4:0] S_SCAN_RD  = 5'd2;
  localparam logic [4:0] S_SCAN_CHK = 5'd3;
  localparam logic [4:0] S_NEXT     = 5'd4;
  localparam logic [4:0] S_DIAG_RD  = 5'd5;
  localparam logic [4:0] S_DIAG_CHK = 5'd6;
  localparam logic [4:0] S_Q_RD     = 5'd7;
  localparam logic [4:0] S_Q_WAIT   = 5'd8;
  localparam logic [4:0] S_N_CHK    = 5'd9;
  localparam logic [4:0] S_PUSH_D   = 5'd10;
  localparam logic [4:0] S_UNDO_Q   = 5'd11;
  localparam logic [4:0] S_UNDO_N   = 5'd12;
  localparam logic [4:0] S_UNDO_W   = 5'd13;
  localparam logic [4:0] S_UNDO_END = 5'd14;
  localparam logic [4:0] S_LIST     = 5'd15;
  localparam logic [4:0] S_DONE     = 5'd16;

  logic          pix_mem  [DEPTH];
  logic [NW-1:0] node_mem [DEPTH];
  logic [AW-1:0] q_mem    [QDEPTH];

  logic [4:0]     state;
  logic [AW:0]    sweep;
  logic [AW-1:0]  sweep_d;
  logic           sweep_v;
  logic [AW-1:0]  sa;
  logic [CW-1:0]  x1, y1, x0, y0;
  logic [AAW-1:0] esq;
  logic [AAW-1:0] area;
  logic [QW:0]    head, tail, ui;
  logic [AW-1:0]  cur;
  logic [LW-1:0]  lenr;
  logic           merge;
  logic           pix_q;
  logic [NW-1:0]  n_q;
  logic [AW-1:0]  q_q;

  logic [LW-1:0] w_used, h_used;
  logic [CW-1:0] sx, sy, cx, cy, wx, wy;
  logic          n_pos, n_neg;
  logic [LW-1:0] n_len, n_mag;
  logic [LW:0]   sum_x, sum_y;
  logic          fail, push_r, push_d;
  logic [LW-1:0] side;
  logic          diag_end, last_cell, in_area;

  logic          n_we;
  logic [AW-1:0] n_wa, n_ra;
  logic [NW-1:0] n_wd;
  logic          q_we;
  logic [QW-1:0] q_wa, q_ra;
  logic [AW-1:0] q_wd;

  assign w_used = (cfg_w > MAX_DIM) ? LW'(MAX_DIM) : LW'(cfg_w);
  assign h_used = (cfg_h > MAX_DIM) ? LW'(MAX_DIM) : LW'(cfg_h);

  assign sx = sa[CW-1:0];
  assign sy = sa[AW-1:CW];
  assign cx = cur[CW-1:0];
  assign cy = cur[AW-1:CW];
  assign wx = sweep_d[CW-1:0];
  assign wy = sweep_d[AW-1:CW];

  assign n_neg = n_q[NW-1];
  assign n_pos = !n_q[NW-1] && (n_q != '0);
  assign n_len = n_q[LW-1:0];
  assign n_mag = LW'(NW'(0) - n_q);

  // The walked square must stay inside the box that ends at (x1, y1).
  assign sum_x  = (LW+1)'(cx) + (LW+1)'(n_len);
  assign sum_y  = (LW+1)'(cy) + (LW+1)'(n_len);
  assign fail   = n_pos && ((sum_x > (LW+1)'(x1) + 1'b1) || (sum_y > (LW+1)'(y1) + 1'b1));
  assign push_r = sum_x <= (LW+1)'(x1);
  assign push_d = sum_y <= (LW+1)'(y1);

  assign side      = LW'(x1) - LW'(x0) + 1'b1;
  assign diag_end  = (x0 == '0) || (y0 == '0);
  assign last_cell = (sa == '1);
  assign in_area   = (LW'(wx) < w_used) && (LW'(wy) < h_used);

  always_comb begin
    n_we = 1'b0;
    n_wa = cur;
    n_wd = '0;
    n_ra = sa;
    q_we = 1'b0;
    q_wa = tail[QW-1:0];
    q_wd = {y0, x0};
    q_ra = head[QW-1:0];
    unique case (state)
      S_INIT: begin
        n_we = sweep_v;
        n_wa = sweep_d;
        n_wd = (pix_q && in_area) ? NW'(1) : '0;
      end
      S_DIAG_RD: n_ra = {y0, x0};
      S_DIAG_CHK: begin
        q_we = n_pos;
        q_wa = '0;
      end
      S_Q_WAIT: n_ra = q_q;
      S_N_CHK: begin
        n_we = !fail && n_pos;
        n_wd = NW'(0) - NW'(n_len);
        q_we = !fail && n_pos && push_r;
        q_wd = {cy, cx + CW'(n_len)};
      end
      S_PUSH_D: begin
        q_we = 1'b1;
        q_wd = {cy + CW'(lenr), cx};
      end
      S_UNDO_Q: q_ra = ui[QW-1:0];
      S_UNDO_N: n_ra = q_q;
      S_UNDO_W: begin
        // Marked squares are either removed (merge) or restored.
        n_we = n_neg;
        n_wd = merge ? '0 : NW'(n_mag);
      end
      S_UNDO_END: begin
        n_we = merge;
        n_wa = {y0, x0};
        n_wd = NW'(side);
      end
      S_LIST: n_ra = sweep[AW-1:0];
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pix_mem[load_addr] <= cmd.load_bit;
    end
    pix_q <= pix_mem[sweep[AW-1:0]];
    if (n_we) begin
      node_mem[n_wa] <= n_wd;
    end
    n_q <= node_mem[n_ra];
    if (q_we) begin
      q_mem[q_wa] <= q_wd;
    end
    q_q <= q_mem[q_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      sweep_v <= 1'b0;
    end else begin
      sweep_v <= ((state == S_INIT) || (state == S_LIST)) && !sweep[AW];
      sweep_d <= sweep[AW-1:0];
      unique case (state)
        S_IDLE: begin
          if (cmd.start) begin
            sweep <= '0;
            state <= S_INIT;
          end
        end
        S_INIT: begin
          if (!sweep[AW]) begin
            sweep <= sweep + 1'b1;
          end else begin
            sa    <= '0;
            state <= S_SCAN_RD;
          end
        end
        S_SCAN_RD: state <= S_SCAN_CHK;
        S_SCAN_CHK: begin
          if (n_pos && (sx != '0) && (sy != '0)) begin
            x1    <= sx;
            y1    <= sy;
            x0    <= sx - 1'b1;
            y0    <= sy - 1'b1;
            state <= S_DIAG_RD;
          end else begin
            state <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (last_cell) begin
            sweep <= '0;
            state <= S_LIST;
          end else begin
            sa    <= sa + 1'b1;
            state <= S_SCAN_RD;
          end
        end
        S_DIAG_RD: state <= S_DIAG_CHK;
        S_DIAG_CHK: begin
          if (n_pos) begin
            head  <= '0;
            tail  <= (QW+1)'(1);
            area  <= '0;
            esq   <= AAW'(side) * AAW'(side);
            state <= S_Q_RD;
          end else if (diag_end) begin
            state <= S_NEXT;
          end else begin
            x0    <= x0 - 1'b1;
            y0    <= y0 - 1'b1;
            state <= S_DIAG_RD;
          end
        end
        S_Q_RD: begin
          if (head == tail) begin
            merge <= (area == esq);
            ui    <= '0;
            state <= S_UNDO_Q;
          end else begin
            head  <= head + 1'b1;
            state <= S_Q_WAIT;
          end
        end
        S_Q_WAIT: begin
          cur   <= q_q;
          state <= S_N_CHK;
        end
        S_N_CHK: begin
          if (fail) begin
            merge <= 1'b0;
            ui    <= '0;
            state <= S_UNDO_Q;
          end else if (n_pos) begin
            area <= area + AAW'(n_len) * AAW'(n_len);
            lenr <= n_len;
            if (push_r) begin
              tail <= tail + 1'b1;
            end
            state <= push_d ? S_PUSH_D : S_Q_RD;
          end else begin
            state <= S_Q_RD;
          end
        end
        S_PUSH_D: begin
          tail  <= tail + 1'b1;
          state <= S_Q_RD;
        end
        S_UNDO_Q: begin
          if (ui == head) begin
            state <= S_UNDO_END;
          end else begin
            ui    <= ui + 1'b1;
            state <= S_UNDO_N;
          end
        end
        S_UNDO_N: begin
          cur   <= q_q;
          state <= S_UNDO_W;
        end
        S_UNDO_W: state <= S_UNDO_Q;
        S_UNDO_END: begin
          if (merge && !diag_end) begin
            x0    <= x0 - 1'b1;
            y0    <= y0 - 1'b1;
            state <= S_DIAG_RD;
          end else begin
            state <= S_NEXT;
          end
        end
        S_LIST: begin
          if (!sweep[AW]) begin
            sweep <= sweep + 1'b1;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign done           = (state == S_DONE);
  assign list_ctl.clear = (state == S_NEXT) && last_cell;
  assign list_ctl.push  = (state == S_LIST) && sweep_v && n_pos;
  assign list_x         = wx;
  assign list_y         = wy;
  assign list_len       = n_len;

`ifndef SYNTHESIS
  a_head_le_tail: assert property (@(posedge clk) disable iff (rst)
    ((state == S_Q_WAIT) || (state == S_N_CHK) || (state == S_PUSH_D)) |-> (head <= tail))
    else $error("walk queue read pointer passed write pointer");
  a_undo_bound: assert property (@(posedge clk) disable iff (rst)
    ((state == S_UNDO_N) || (state == S_UNDO_W)) |-> (ui <= head))
    else $error("undo pass ran beyond the walked entries");
`endif

endmodule

### hdl/gsp_list.sv
// ----------------------------------------------------------------------------
// gsp_list
// Square list memory and square count; answers indexed reads.
// ----------------------------------------------------------------------------
module gsp_list #(
  parameter int MAX_DIM = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  gsp_pkg::list_ctl_t                list_ctl,
  input  logic [$clog2(MAX_DIM)-1:0]        list_x,
  input  logic [$clog2(MAX_DIM)-1:0]        list_y,
  input  logic [$clog2(MAX_DIM):0]          list_len,
  input  logic                              rd_en,
  input  logic [gsp_pkg::IDX_W-1:0]         rd_index,
  output logic [2*$clog2(MAX_DIM):0]        count,
  output logic                              rd_hit,
  output logic [$clog2(MAX_DIM)-1:0]        rd_x,
  output logic [$clog2(MAX_DIM)-1:0]        rd_y,
  output logic [$clog2(MAX_DIM):0]          rd_len
);

  localparam int CW    = $clog2(MAX_DIM);
  localparam int LW    = CW + 1;
  localparam int AW    = 2 * CW;
  localparam int DEPTH = 1 << AW;
  localparam int EW    = LW + 2 * CW;

  logic [EW-1:0] sq_mem [DEPTH];
  logic [EW-1:0] rd_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (list_ctl.clear) begin
      count <= '0;
    end else if (list_ctl.push) begin
      count <= count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (list_ctl.push) begin
      sq_mem[count[AW-1:0]] <= {list_len, list_y, list_x};
    end
    if (rd_en) begin
      rd_word <= sq_mem[AW'(rd_index)];
      rd_hit  <= 32'(rd_index) < 32'(count);
    end
  end

  assign rd_x   = rd_word[CW-1:0];
  assign rd_y   = rd_word[2*CW-1:CW];
  assign rd_len = rd_word[EW-1:2*CW];

endmodule

### hdl/greedy_square_partition_top.sv
// ----------------------------------------------------------------------------
// greedy_square_partition_top
// Greedy square partition of a binary image held in on-chip memory.
// ----------------------------------------------------------------------------
// Usage: items arrive on the s_axis channel, tuser carrying the action. A load
// writes one pixel, a run partitions the image, a read returns one square of
// the last run by index. Every transaction yields exactly one result on the
// m_axis channel, always carrying the current square count.
// A load or an unknown action registers its result at acceptance, a read
// once the list memory word is read, from the T_READ state. A run sweeps all
// DEPTH node addresses to initialise and again to list, where DEPTH is
// MAX_DIM rounded up to a power of two, squared; between them it scans each
// cell, steps along diagonals and, per candidate square, runs a tiling test
// over the walk queue and an undo pass. One item is in work at a time;
// s_axis_tready is low while an item is in work or while a result waits that
// the receiver does not take.
// Reset clears the count, so reads answer invalid until a run completes; the
// width and height registers return to 64. When the receiver stalls, the
// result holds in the output register and no further item is taken.
// ----------------------------------------------------------------------------
module greedy_square_partition_top #(
  parameter int MAX_DIM = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // pixel_x[5:0], pixel_y[11:6], pixel_bit[12], square_index[24:13], zero pad
  input  logic [31:0] s_axis_tdata,
  // action[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // square_count[12:0], corner_x[18:13], corner_y[24:19], side_length[31:25],
  // index_valid[32], zero pad
  output logic [39:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic [gsp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gsp_pkg::CFG_REG_W-1:0] cfg_data
);

  localparam int CW = $clog2(MAX_DIM);
  localparam int LW = CW + 1;
  localparam int AW = 2 * CW;

  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_RUN  = 2'd1;
  localparam logic [1:0] T_READ = 2'd2;

  logic [1:0] state;
  logic [gsp_pkg::CFG_REG_W-1:0] cfg_w, cfg_h;

  logic [gsp_pkg::ACT_W-1:0] action;
  logic [gsp_pkg::POS_W-1:0] px, py;
  logic                      pbit;
  logic [gsp_pkg::IDX_W-1:0] sidx;
  logic                      accept, load_ok;

  gsp_pkg::run_cmd_t  cmd;
  gsp_pkg::list_ctl_t list_ctl;
  logic               done, rd_en, rd_hit;
  logic [CW-1:0]      list_x, list_y, rd_x, rd_y;
  logic [LW-1:0]      list_len, rd_len;
  logic [AW:0]        count;

  logic [gsp_pkg::CNT_W-1:0] o_count;
  logic [gsp_pkg::POS_W-1:0] o_x, o_y;
  logic [gsp_pkg::LEN_W-1:0] o_len;
  logic                      o_hit;

  assign action = s_axis_tuser;
  assign px     = s_axis_tdata[5:0];
  assign py     = s_axis_tdata[11:6];
  assign pbit   = s_axis_tdata[12];
  assign sidx   = s_axis_tdata[24:13];

  assign s_axis_tready = (state == T_IDLE) && (!m_axis_tvalid || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign load_ok       = (32'(px) < MAX_DIM) && (32'(py) < MAX_DIM);

  assign cmd.start    = accept && (action == gsp_pkg::ACT_RUN);
  assign cmd.load     = accept && (action == gsp_pkg::ACT_LOAD) && load_ok;
  assign cmd.load_bit = pbit;
  assign rd_en        = accept && (action == gsp_pkg::ACT_READ);

  gsp_run #(.MAX_DIM(MAX_DIM)) u_run (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .load_addr ({CW'(py), CW'(px)}),
    .cfg_w     (cfg_w),
    .cfg_h     (cfg_h),
    .done      (done),
    .list_ctl  (list_ctl),
    .list_x    (list_x),
    .list_y    (list_y),
    .list_len  (list_len)
  );

  gsp_list #(.MAX_DIM(MAX_DIM)) u_list (
    .clk      (clk),
    .rst      (rst),
    .list_ctl (list_ctl),
    .list_x   (list_x),
    .list_y   (list_y),
    .list_len (list_len),
    .rd_en    (rd_en),
    .rd_index (sidx),
    .count    (count),
    .rd_hit   (rd_hit),
    .rd_x     (rd_x),
    .rd_y     (rd_y),
    .rd_len   (rd_len)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= T_IDLE;
      m_axis_tvalid <= 1'b0;
      cfg_w         <= gsp_pkg::CFG_REG_W'(64);
      cfg_h         <= gsp_pkg::CFG_REG_W'(64);
    end else begin
      if (cfg_we) begin
        if (cfg_index == gsp_pkg::CFG_WIDTH) begin
          cfg_w <= cfg_data;
        end else if (cfg_index == gsp_pkg::CFG_HEIGHT) begin
          cfg_h <= cfg_data;
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        T_IDLE: begin
          if (accept) begin
            unique case (action)
              gsp_pkg::ACT_RUN:  state <= T_RUN;
              gsp_pkg::ACT_READ: state <= T_READ;
              default: begin
                m_axis_tvalid <= 1'b1;
                o_count       <= gsp_pkg::CNT_W'(count);
                o_x           <= '0;
                o_y           <= '0;
                o_len         <= '0;
                o_hit         <= 1'b0;
              end
            endcase
          end
        end
        T_RUN: begin
          if (done) begin
            m_axis_tvalid <= 1'b1;
            o_count       <= gsp_pkg::CNT_W'(count);
            o_x           <= '0;
            o_y           <= '0;
            o_len         <= '0;
            o_hit         <= 1'b0;
            state         <= T_IDLE;
          end
        end
        T_READ: begin
          m_axis_tvalid <= 1'b1;
          o_count       <= gsp_pkg::CNT_W'(count);
          o_x           <= rd_hit ? gsp_pkg::POS_W'(rd_x) : '0;
          o_y           <= rd_hit ? gsp_pkg::POS_W'(rd_y) : '0;
          o_len         <= rd_hit ? gsp_pkg::LEN_W'(rd_len) : '0;
          o_hit         <= rd_hit;
          state         <= T_IDLE;
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  assign m_axis_tdata = {7'b0, o_hit, o_len, o_y, o_x, o_count};

`ifndef SYNTHESIS
  a_slot_free: assert property (@(posedge clk) disable iff (rst)
    (state != T_IDLE) |-> !m_axis_tvalid)
    else $error("result pending while an item is in work");
  a_done_in_run: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == T_RUN))
    else $error("partition finished without a run in progress");
`endif

endmodule
